/* design/papa_pkg.sv */
`timescale 1ns / 1ps

package papa_pkg;

    localparam int AMP_BITS   = 16;
    localparam int TIME_BITS  = 32;
    localparam int CNT_BITS   = 16;
    // peak amplitude sum: up to 2**CNT_BITS - 1 peaks of AMP_BITS each
    localparam int SUM_BITS   = AMP_BITS + CNT_BITS;
    // period sum: at most half of the peaks form pairs
    localparam int PSUM_BITS  = TIME_BITS + CNT_BITS;
    localparam int DIV_BITS   = PSUM_BITS;
    localparam int STEP_BITS  = $clog2(DIV_BITS);
    localparam int FILL_BITS  = 3;

    localparam logic [FILL_BITS-1:0] FILL_FULL = FILL_BITS'(4);
    localparam logic [CNT_BITS-1:0]  CNT_MAX   = '1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // totals of one finished record
    typedef struct packed {
        logic signed [SUM_BITS-1:0] amp_sum;
        logic [PSUM_BITS-1:0]       period_sum;
        logic [CNT_BITS-1:0]        peak_total;
        logic [CNT_BITS-1:0]        pair_total;
    } t_summary;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV_AMP,
        S_DIV_PER,
        S_DONE
    } t_back_state;

    typedef struct packed {
        logic pop;
        logic step;
        logic amp_done;
        logic per_done;
        logic load_out;
    } t_back_ctl;

endpackage

/* design/papa_front.sv */
`timescale 1ns / 1ps

module papa_front import papa_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic                       i_q_full,
    input  logic [TIME_BITS-1:0]       i_sample_time,
    input  logic signed [AMP_BITS-1:0] i_sample_amplitude,
    input  logic                       i_last_sample,
    output logic                       o_q_push,
    output t_summary                   o_summary
);

    logic signed [AMP_BITS-1:0]  r_amp_win [4];
    logic [TIME_BITS-1:0]        r_time_win [2];
    logic [FILL_BITS-1:0]        r_fill;
    logic signed [SUM_BITS-1:0]  r_amp_sum, n_amp_sum;
    logic [CNT_BITS-1:0]         r_peak_total, n_peak_total;
    logic                        r_pair_open, n_pair_open;
    logic [TIME_BITS-1:0]        r_open_time, n_open_time;
    logic [PSUM_BITS-1:0]        r_period_sum, n_period_sum;
    logic [CNT_BITS-1:0]         r_pair_total, n_pair_total;

    logic                        accept;
    logic                        is_peak;
    logic                        take;
    logic signed [AMP_BITS-1:0]  center;
    logic [TIME_BITS-1:0]        diff;

    assign accept = i_push & ~i_q_full;
    assign center = r_amp_win[1];
    // center of the five-sample window must beat all four neighbors
    assign is_peak = (r_fill == FILL_FULL) && (center > r_amp_win[0]) &&
                     (center > i_sample_amplitude) && (center > r_amp_win[2]) &&
                     (center > r_amp_win[3]);
    // a saturated peak count drops further peaks entirely
    assign take = is_peak && (r_peak_total != CNT_MAX);
    assign diff = r_time_win[1] - r_open_time;

    always_comb begin
        n_amp_sum    = r_amp_sum;
        n_peak_total = r_peak_total;
        n_pair_open  = r_pair_open;
        n_open_time  = r_open_time;
        n_period_sum = r_period_sum;
        n_pair_total = r_pair_total;
        if (take) begin
            n_amp_sum    = r_amp_sum + SUM_BITS'(center);
            n_peak_total = r_peak_total + CNT_BITS'(1);
            if (!r_pair_open) begin
                n_open_time = r_time_win[1];
                n_pair_open = 1'b1;
            end else begin
                n_period_sum = r_period_sum + PSUM_BITS'(diff);
                if (r_pair_total != CNT_MAX) begin
                    n_pair_total = r_pair_total + CNT_BITS'(1);
                end
                n_pair_open = 1'b0;
            end
        end
    end

    assign o_q_push             = accept & i_last_sample;
    assign o_summary.amp_sum    = n_amp_sum;
    assign o_summary.period_sum = n_period_sum;
    assign o_summary.peak_total = n_peak_total;
    assign o_summary.pair_total = n_pair_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= '0;
            r_amp_sum    <= '0;
            r_peak_total <= '0;
            r_pair_open  <= 1'b0;
            r_period_sum <= '0;
            r_pair_total <= '0;
        end else if (accept) begin
            if (i_last_sample) begin
                r_fill       <= '0;
                r_amp_sum    <= '0;
                r_peak_total <= '0;
                r_pair_open  <= 1'b0;
                r_period_sum <= '0;
                r_pair_total <= '0;
            end else begin
                if (r_fill != FILL_FULL) begin
                    r_fill <= r_fill + FILL_BITS'(1);
                end
                r_amp_sum    <= n_amp_sum;
                r_peak_total <= n_peak_total;
                r_pair_open  <= n_pair_open;
                r_period_sum <= n_period_sum;
                r_pair_total <= n_pair_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_amp_win[3]  <= r_amp_win[2];
            r_amp_win[2]  <= r_amp_win[1];
            r_amp_win[1]  <= r_amp_win[0];
            r_amp_win[0]  <= i_sample_amplitude;
            r_time_win[1] <= r_time_win[0];
            r_time_win[0] <= i_sample_time;
            r_open_time   <= n_open_time;
        end
    end

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_FULL)
        else $error("front: fill level out of range");

    a_record_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last_sample) |=> (r_fill == '0 && r_peak_total == '0 && !r_pair_open))
        else $error("front: state not cleared after record end");

endmodule

/* design/papa_queue.sv */
`timescale 1ns / 1ps

module papa_queue import papa_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_summary i_data,
    input  logic     i_pop,
    output logic     o_full,
    output logic     o_empty,
    output t_summary o_data
);

    t_summary               r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   r_wr_ptr;
    logic [QPTR_BITS-1:0]   r_rd_ptr;
    logic [QCNT_BITS-1:0]   r_count;
    logic                   do_push;
    logic                   do_pop;

    assign o_full  = (r_count == QCNT_BITS'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                    : r_wr_ptr + QPTR_BITS'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                    : r_rd_ptr + QPTR_BITS'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_BITS'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_push_into_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_empty && i_push) |=> !o_empty)
        else $error("queue: pushed word lost");

endmodule

/* design/papa_back.sv */
`timescale 1ns / 1ps

module papa_back import papa_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_empty,
    input  t_summary                   i_summary,
    output logic                       o_q_pop,
    input  logic                       i_pop,
    output logic                       o_empty,
    output logic signed [AMP_BITS-1:0] o_mean_amplitude,
    output logic [TIME_BITS-1:0]       o_mean_period,
    output logic [CNT_BITS-1:0]        o_peak_count,
    output logic [CNT_BITS-1:0]        o_interval_count,
    output logic                       o_amplitude_valid,
    output logic                       o_period_valid
);

    t_back_state                 r_state, n_state;
    t_back_ctl                   ctl;

    t_summary                    r_job;
    logic [DIV_BITS-1:0]         r_quo;
    logic [CNT_BITS-1:0]         r_rem;
    logic [CNT_BITS-1:0]         r_div;
    logic [STEP_BITS-1:0]        r_cnt;
    logic                        r_neg;
    logic [AMP_BITS-1:0]         r_mean_amp;
    logic [TIME_BITS-1:0]        r_mean_per;

    logic                        r_out_valid;
    logic [AMP_BITS-1:0]         r_out_amp;
    logic [TIME_BITS-1:0]        r_out_per;
    logic [CNT_BITS-1:0]         r_out_peaks;
    logic [CNT_BITS-1:0]         r_out_pairs;
    logic                        r_out_amp_ok;
    logic                        r_out_per_ok;

    logic [CNT_BITS:0]           rem_shift;
    logic [CNT_BITS:0]           rem_sub;
    logic                        fits;
    logic [CNT_BITS-1:0]         rem_step;
    logic [DIV_BITS-1:0]         quo_step;
    logic                        last_step;
    logic [SUM_BITS-1:0]         amp_mag;
    logic [AMP_BITS-1:0]         amp_q;

    // restoring divider, one quotient bit per cycle
    assign rem_shift = {r_rem, r_quo[DIV_BITS-1]};
    assign rem_sub   = rem_shift - {1'b0, r_div};
    assign fits      = (rem_shift >= {1'b0, r_div});
    assign rem_step  = fits ? rem_sub[CNT_BITS-1:0] : rem_shift[CNT_BITS-1:0];
    assign quo_step  = {r_quo[DIV_BITS-2:0], fits};
    assign last_step = (r_cnt == '0);

    // divide magnitudes, restore sign: truncation toward zero
    assign amp_mag = i_summary.amp_sum[SUM_BITS-1] ? SUM_BITS'(-i_summary.amp_sum)
                                                   : SUM_BITS'(i_summary.amp_sum);
    assign amp_q   = quo_step[AMP_BITS-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (!i_q_empty) n_state = S_DIV_AMP;
            S_DIV_AMP: if (last_step) n_state = S_DIV_PER;
            S_DIV_PER: if (last_step) n_state = S_DONE;
            S_DONE:    if (!r_out_valid || i_pop) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        ctl = '0;
        unique case (r_state)
            S_IDLE: begin
                ctl.pop = ~i_q_empty;
            end
            S_DIV_AMP: begin
                ctl.step     = 1'b1;
                ctl.amp_done = last_step;
            end
            S_DIV_PER: begin
                ctl.step     = 1'b1;
                ctl.per_done = last_step;
            end
            S_DONE: begin
                ctl.load_out = ~r_out_valid | i_pop;
            end
            default: ctl = '0;
        endcase
    end

    assign o_q_pop = ctl.pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ctl.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.pop) begin
            r_job <= i_summary;
            r_quo <= DIV_BITS'(amp_mag);
            r_rem <= '0;
            r_div <= i_summary.peak_total;
            r_neg <= i_summary.amp_sum[SUM_BITS-1];
            r_cnt <= STEP_BITS'(DIV_BITS - 1);
        end else if (ctl.amp_done) begin
            r_mean_amp <= r_neg ? AMP_BITS'(-amp_q) : amp_q;
            r_quo      <= r_job.period_sum;
            r_rem      <= '0;
            r_div      <= r_job.pair_total;
            r_cnt      <= STEP_BITS'(DIV_BITS - 1);
        end else if (ctl.step) begin
            r_quo <= quo_step;
            r_rem <= rem_step;
            r_cnt <= r_cnt - STEP_BITS'(1);
            if (ctl.per_done) begin
                r_mean_per <= quo_step[TIME_BITS-1:0];
            end
        end
    end

    // a zero divisor leaves an all-ones quotient: masked here
    always_ff @(posedge i_clk) begin
        if (ctl.load_out) begin
            r_out_amp_ok <= (r_job.peak_total != '0);
            r_out_per_ok <= (r_job.pair_total != '0);
            r_out_amp    <= (r_job.peak_total != '0) ? r_mean_amp : '0;
            r_out_per    <= (r_job.pair_total != '0) ? r_mean_per : '0;
            r_out_peaks  <= r_job.peak_total;
            r_out_pairs  <= r_job.pair_total;
        end
    end

    assign o_empty           = ~r_out_valid;
    assign o_mean_amplitude  = r_out_amp;
    assign o_mean_period     = r_out_per;
    assign o_peak_count      = r_out_peaks;
    assign o_interval_count  = r_out_pairs;
    assign o_amplitude_valid = r_out_amp_ok;
    assign o_period_valid    = r_out_per_ok;

    a_divisor_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DIV_AMP || r_state == S_DIV_PER) && !last_step) |=> $stable(r_div))
        else $error("back: divisor changed during division");

    a_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !i_pop) |=> (r_state == S_DONE))
        else $error("back: result overwrote a waiting word");

endmodule

/* design/peak_amplitude_period_averager.sv */
`timescale 1ns / 1ps

// Five-point peak detector with per-record averaging. Samples are taken at one
// per cycle while full is low; a sample is a peak when it is strictly greater
// than the two samples before and the two after it in the same record. The word
// marked last_sample closes the record: its totals go into a two-word queue and
// the detector state clears at once, so the next record can start on the
// following cycle. One shared restoring divider (one quotient bit per cycle)
// then works out mean amplitude and mean period of paired peaks: a load from
// the queue, the amplitude divide steps, the period divide steps, a hand-off.
// full rises only when both queue words hold records waiting for the divider.
module peak_amplitude_period_averager import papa_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [TIME_BITS-1:0]       i_sample_time,
    input  logic signed [AMP_BITS-1:0] i_sample_amplitude,
    input  logic                       i_last_sample,
    output logic                       empty,
    input  logic                       pop,
    output logic signed [AMP_BITS-1:0] o_mean_amplitude,
    output logic [TIME_BITS-1:0]       o_mean_period,
    output logic [CNT_BITS-1:0]        o_peak_count,
    output logic [CNT_BITS-1:0]        o_interval_count,
    output logic                       o_amplitude_valid,
    output logic                       o_period_valid
);

    logic     q_push;
    logic     q_full;
    logic     q_empty;
    logic     q_pop;
    t_summary q_in;
    t_summary q_out;

    assign full = q_full;

    papa_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_push             (push),
        .i_q_full           (q_full),
        .i_sample_time      (i_sample_time),
        .i_sample_amplitude (i_sample_amplitude),
        .i_last_sample      (i_last_sample),
        .o_q_push           (q_push),
        .o_summary          (q_in)
    );

    papa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    papa_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_empty         (q_empty),
        .i_summary         (q_out),
        .o_q_pop           (q_pop),
        .i_pop             (pop),
        .o_empty           (empty),
        .o_mean_amplitude  (o_mean_amplitude),
        .o_mean_period     (o_mean_period),
        .o_peak_count      (o_peak_count),
        .o_interval_count  (o_interval_count),
        .o_amplitude_valid (o_amplitude_valid),
        .o_period_valid    (o_period_valid)
    );

endmodule

/* bench/peak_average_checker.sv */
`timescale 1ns / 1ps

module peak_average_checker import papa_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic                       i_full,
    input  logic [TIME_BITS-1:0]       i_sample_time,
    input  logic signed [AMP_BITS-1:0] i_sample_amplitude,
    input  logic                       i_last_sample,
    input  logic                       i_empty,
    input  logic                       i_pop,
    input  logic signed [AMP_BITS-1:0] i_mean_amplitude,
    input  logic [TIME_BITS-1:0]       i_mean_period,
    input  logic [CNT_BITS-1:0]        i_peak_count,
    input  logic [CNT_BITS-1:0]        i_interval_count,
    input  logic                       i_amplitude_valid,
    input  logic                       i_period_valid,
    output int                         o_errors,
    output int                         o_pending
);

    typedef struct packed {
        logic signed [AMP_BITS-1:0] mean_amp;
        logic [TIME_BITS-1:0]       mean_per;
        logic [CNT_BITS-1:0]        peaks;
        logic [CNT_BITS-1:0]        pairs;
        logic                       amp_ok;
        logic                       per_ok;
    } t_record_mean;

    t_record_mean expected_averages[$];
    t_record_mean want;
    int           err_count = 0;

    // per-record detector state
    logic signed [AMP_BITS-1:0] amp_hist [4];
    logic [TIME_BITS-1:0]       time_hist [2];
    int unsigned                fill;
    longint                     amp_acc;
    int unsigned                peaks;
    int unsigned                pairs;
    bit                         pair_waiting;
    logic [TIME_BITS-1:0]       pair_start;
    logic [63:0]                period_acc;

    function automatic void clear_record();
        for (int k = 0; k < 4; k++) amp_hist[k] = '0;
        time_hist[0] = '0;
        time_hist[1] = '0;
        fill         = 0;
        amp_acc      = 0;
        peaks        = 0;
        pairs        = 0;
        pair_waiting = 1'b0;
        pair_start   = '0;
        period_acc   = '0;
    endfunction

    task automatic absorb_sample(input logic [TIME_BITS-1:0] t,
                                 input logic signed [AMP_BITS-1:0] a,
                                 input logic last);
        logic signed [AMP_BITS-1:0] mid;
        logic [TIME_BITS-1:0]       gap;
        t_record_mean               avg;
        mid = amp_hist[1];
        // peak is settled two words late; past a full count, peaks are dropped entirely
        if (fill >= 4 && mid > amp_hist[0] && mid > a && mid > amp_hist[2]
                && mid > amp_hist[3] && peaks < CNT_MAX) begin
            amp_acc += mid;
            peaks++;
            if (!pair_waiting) begin
                pair_start   = time_hist[1];
                pair_waiting = 1'b1;
            end else begin
                gap = time_hist[1] - pair_start;   // wraps on decreasing stamps
                if (period_acc > ~64'd0 - gap)
                    period_acc = ~64'd0;
                else
                    period_acc += gap;
                if (pairs < CNT_MAX)
                    pairs++;
                pair_waiting = 1'b0;
            end
        end
        amp_hist[3]  = amp_hist[2];
        amp_hist[2]  = amp_hist[1];
        amp_hist[1]  = amp_hist[0];
        amp_hist[0]  = a;
        time_hist[1] = time_hist[0];
        time_hist[0] = t;
        if (fill < 4)
            fill++;
        if (last) begin
            avg.amp_ok   = (peaks != 0);
            avg.per_ok   = (pairs != 0);
            avg.mean_amp = (peaks != 0) ? AMP_BITS'(amp_acc / longint'(peaks)) : '0;
            avg.mean_per = (pairs != 0) ? TIME_BITS'(period_acc / 64'(pairs)) : '0;
            avg.peaks    = CNT_BITS'(peaks);
            avg.pairs    = CNT_BITS'(pairs);
            expected_averages.insert(expected_averages.size(), avg);
            clear_record();
        end
    endtask

    task automatic check_field(input string name, input longint want_v, input longint got_v);
        if (want_v != got_v) begin
            err_count++;
            $display("%0t: %s mismatch: expected %0d, got %0d",
                     $time, name, want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_record();
            expected_averages.delete();
        end else begin
            // pop side first: a word leaving is always older than one being queued
            if (i_pop && !i_empty) begin
                if (expected_averages.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected result word: expected none, got amp %0d",
                             $time, i_mean_amplitude);
                end else begin
                    want = expected_averages.pop_front();
                    check_field("mean_amplitude", longint'($signed(want.mean_amp)),
                                longint'(i_mean_amplitude));
                    check_field("mean_period", longint'(want.mean_per),
                                longint'(i_mean_period));
                    check_field("peak_count", longint'(want.peaks), longint'(i_peak_count));
                    check_field("interval_count", longint'(want.pairs),
                                longint'(i_interval_count));
                    check_field("amplitude_valid", longint'(want.amp_ok),
                                longint'(i_amplitude_valid));
                    check_field("period_valid", longint'(want.per_ok),
                                longint'(i_period_valid));
                end
            end
            if (i_push && !i_full)
                absorb_sample(i_sample_time, i_sample_amplitude, i_last_sample);
        end
        o_errors  <= err_count;
        o_pending <= expected_averages.size();
    end

endmodule

/* bench/tb_peak_amplitude_period_averager.sv */
`timescale 1ns / 1ps

module tb_peak_amplitude_period_averager;
    import papa_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_WORDS = 1900;
    localparam int DRAIN_CYCLES = 300;

    typedef enum int {
        SHAPE_HILLS,
        SHAPE_NOISE,
        SHAPE_FLAT,
        SHAPE_RAIL
    } t_shape;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       push = 1'b0;
    logic                       full;
    logic [TIME_BITS-1:0]       sample_time = '0;
    logic signed [AMP_BITS-1:0] sample_amplitude = '0;
    logic                       last_sample = 1'b0;
    logic                       empty;
    logic                       pop = 1'b0;
    logic signed [AMP_BITS-1:0] mean_amplitude;
    logic [TIME_BITS-1:0]       mean_period;
    logic [CNT_BITS-1:0]        peak_count;
    logic [CNT_BITS-1:0]        interval_count;
    logic                       amplitude_valid;
    logic                       period_valid;

    int fail_count;
    int pending;
    int sent = 0;
    int tx_idle_pct = 16;
    int rx_idle_pct = 74;
    bit burst = 1'b0;
    int stall_cycles = 0;

    always #10 i_clk = ~i_clk;

    peak_amplitude_period_averager DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .push               (push),
        .full               (full),
        .i_sample_time      (sample_time),
        .i_sample_amplitude (sample_amplitude),
        .i_last_sample      (last_sample),
        .empty              (empty),
        .pop                (pop),
        .o_mean_amplitude   (mean_amplitude),
        .o_mean_period      (mean_period),
        .o_peak_count       (peak_count),
        .o_interval_count   (interval_count),
        .o_amplitude_valid  (amplitude_valid),
        .o_period_valid     (period_valid)
    );

    peak_average_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_push             (push),
        .i_full             (full),
        .i_sample_time      (sample_time),
        .i_sample_amplitude (sample_amplitude),
        .i_last_sample      (last_sample),
        .i_empty            (empty),
        .i_pop              (pop),
        .i_mean_amplitude   (mean_amplitude),
        .i_mean_period      (mean_period),
        .i_peak_count       (peak_count),
        .i_interval_count   (interval_count),
        .i_amplitude_valid  (amplitude_valid),
        .i_period_valid     (period_valid),
        .o_errors           (fail_count),
        .o_pending          (pending)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n)
            pop <= 1'b0;
        else
            pop <= ($urandom_range(99) >= rx_idle_pct);
    end

    // ends the run if no word moves on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_peak_amplitude_period_averager: errors");
            $finish;
        end
    end

    task automatic send_word(input logic [TIME_BITS-1:0] t,
                             input int a,
                             input logic last);
        while (!burst && tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push             <= 1'b1;
        sample_time      <= t;
        sample_amplitude <= AMP_BITS'(a);
        last_sample      <= last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sent++;
    endtask

    task automatic send_random_record();
        int                   len;
        int                   r;
        int                   spacing;
        int                   base;
        int                   v;
        t_shape               shape;
        logic [TIME_BITS-1:0] t;
        bit                   jumpy;
        r = $urandom_range(19);
        if (r < 4)
            len = $urandom_range(5, 1);
        else if (r == 19)
            len = $urandom_range(150, 60);
        else
            len = $urandom_range(40, 6);
        r = $urandom_range(9);
        shape = (r < 5) ? SHAPE_HILLS : (r < 7) ? SHAPE_NOISE : (r < 9) ? SHAPE_FLAT : SHAPE_RAIL;
        spacing = $urandom_range(6, 3);
        base    = int'($urandom_range(52768)) - 32768;
        t       = $urandom();
        jumpy   = ($urandom_range(3) == 0);
        for (int k = 0; k < len; k++) begin
            case (shape)
                SHAPE_HILLS: begin
                    if (k % spacing == spacing - 1)
                        v = base + int'($urandom_range(12000, 1));
                    else
                        v = base - int'($urandom_range(50));
                    if (v < -32768)
                        v = -32768;
                end
                SHAPE_NOISE: v = int'($urandom_range(65535)) - 32768;
                SHAPE_FLAT:  v = int'($urandom_range(2)) - 1;
                default: begin
                    case ($urandom_range(3))
                        0:       v = 32767;
                        1:       v = -32768;
                        2:       v = 32766;
                        default: v = -32767;
                    endcase
                end
            endcase
            send_word(t, v, k == len - 1);
            t = jumpy ? $urandom() : t + $urandom_range(5000);
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single-word record
        send_word(32'h0000_0000, -32768, 1'b1);
        // two words at the top rail: edges are never peaks
        send_word(32'h0000_0001, 32767, 1'b0);
        send_word(32'h0000_0002, 32767, 1'b1);
        // shortest record holding a peak, left unpaired
        send_word(32'hFFFF_FFFF, -32768, 1'b0);
        send_word(32'hFFFF_FFFF, -32768, 1'b0);
        send_word(32'h0000_0000, 32767, 1'b0);
        send_word(32'hFFFF_FFFF, -32768, 1'b0);
        send_word(32'hFFFF_FFFF, -32768, 1'b1);
        // two negative peaks, second stamp earlier than the first
        send_word(32'd10, -9, 1'b0);
        send_word(32'd20, -9, 1'b0);
        send_word(32'd1000, -3, 1'b0);
        send_word(32'd30, -9, 1'b0);
        send_word(32'd40, -9, 1'b0);
        send_word(32'd400, -2, 1'b0);
        send_word(32'd50, -9, 1'b0);
        send_word(32'd60, -9, 1'b1);
        // flat top: equal neighbors block a peak
        send_word(32'd1, 0, 1'b0);
        send_word(32'd2, 0, 1'b0);
        send_word(32'd3, 5, 1'b0);
        send_word(32'd4, 5, 1'b0);
        send_word(32'd5, 0, 1'b0);
        send_word(32'd6, 0, 1'b1);

        while (sent < RANDOM_WORDS) begin
            if (sent < 640) begin
                tx_idle_pct = 16;
                rx_idle_pct = 74;
            end else if (sent < 1280) begin
                tx_idle_pct = 74;
                rx_idle_pct = 16;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            burst = ($urandom_range(7) == 0);
            send_random_record();
        end
        push <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_peak_amplitude_period_averager: clean");
        else
            $display("tb_peak_amplitude_period_averager: errors");
        $finish;
    end

endmodule

/* sim.f */
design/papa_pkg.sv
design/papa_front.sv
design/papa_queue.sv
design/papa_back.sv
design/peak_amplitude_period_averager.sv
bench/peak_average_checker.sv
bench/tb_peak_amplitude_period_averager.sv
